// File: hdl/icpd_pkg.sv
// ----------------------------------------------------------------------------
// icpd_pkg
// shared types and constants for the command packet dispatcher
// ----------------------------------------------------------------------------
package icpd_pkg;

    // item kinds on the command channel
    typedef enum logic
    {
        OP_PACKET = 1'b0,
        OP_TICK   = 1'b1
    } opcode_t;

    // packet and lens driver codes
    localparam logic [7:0] LOCAL_MARK       = 8'hFE;
    localparam logic [7:0] LENS_ADDR        = 8'hEE;
    localparam logic [7:0] LENS_REG         = 8'h08;
    localparam logic [7:0] LENS_TAIL        = 8'h02;
    localparam logic [7:0] LOCAL_CMD_IMU    = 8'h00;
    localparam logic [7:0] LOCAL_CMD_PLANES = 8'h01;
    localparam logic [7:0] LEN_OVERHEAD     = 8'd2;

    localparam logic [2:0] FULL_DATA_COUNT  = 3'd4;
    localparam logic [2:0] LENS_DATA_COUNT  = 3'd2;
    localparam logic [7:0] SHORT_DATA_MAX   = 8'd3;

    // plane table limits
    localparam int PLANE_SLOTS         = 3;
    localparam int MAX_PLANES_DEFAULT  = 3;

    typedef struct packed
    {
        opcode_t    opcode;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [7:0] byte4;
        logic [7:0] byte5;
    } cmd_t;

    typedef struct packed
    {
        logic       write_valid;
        logic [7:0] dev_address;
        logic [7:0] reg_byte;
        logic [2:0] data_count;
        logic [7:0] data_0;
        logic [7:0] data_1;
        logic [7:0] data_2;
        logic [7:0] data_3;
        logic       imu_enabled;
        logic [1:0] plane_now;
    } res_t;

    // control state carried between the top level and the decoder
    typedef struct packed
    {
        logic       imu_en;
        logic [1:0] plane_count;
        logic [1:0] plane_index;
    } ctrl_state_t;

endpackage

// File: hdl/icpd_cmd_if.sv
// ----------------------------------------------------------------------------
// icpd_cmd_if
// valid/ready channel carrying one command packet or frame tick
// ----------------------------------------------------------------------------
interface icpd_cmd_if import icpd_pkg::*; ();

    logic valid;
    logic ready;
    cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// File: hdl/icpd_res_if.sv
// ----------------------------------------------------------------------------
// icpd_res_if
// valid/ready channel carrying one dispatcher result
// ----------------------------------------------------------------------------
interface icpd_res_if import icpd_pkg::*; ();

    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// File: hdl/i2c_command_packet_dispatcher_core.sv
// ----------------------------------------------------------------------------
// i2c_command_packet_dispatcher_core
// turns host command packets and frame ticks into i2c write requests
// ----------------------------------------------------------------------------
// Every transfer on cmd yields exactly one transfer on res, from the result
// register, and a new item can be taken every cycle while the skid register is
// empty. The decode is a single level of byte muxing and a small wrap counter
// between the accepting edge and the result register; a skid register behind
// it lets cmd keep taking an item while a result is still held by res.
// cmd.ready drops only when both the result register and the skid register
// are full, and it is driven from a register. Local packets (first byte 0xFE)
// set the imu flag or load the lens plane table, and produce a result with
// write_valid low. With planes loaded, frame ticks step the plane index round
// the count and request a write of the plane's value to the lens driver. Every
// result carries the imu flag and plane index as they stand after its item.
// ----------------------------------------------------------------------------
module i2c_command_packet_dispatcher_core import icpd_pkg::*;
#(
    parameter int MAX_PLANES = MAX_PLANES_DEFAULT    // 1 to 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    icpd_cmd_if.sink          cmd,
    icpd_res_if.source        res
);

    // dispatcher state
    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic [7:0]  plane_values_reg  [MAX_PLANES];
    logic [7:0]  plane_values_next [MAX_PLANES];

    // result register and skid register
    res_t        out_reg;
    logic        out_valid_reg;
    res_t        skid_reg;
    logic        skid_valid_reg;

    res_t        result;
    logic        cmd_xfer;
    logic        out_free;

    icpd_decode
    #(
        .MAX_PLANES (MAX_PLANES)
    )
    u_decode
    (
        .cmd               (cmd.data),
        .state             (state_reg),
        .plane_values      (plane_values_reg),
        .state_next        (state_next),
        .plane_values_next (plane_values_next),
        .result            (result)
    );

    // take a new item unless the skid stage is occupied
    assign cmd.ready = !skid_valid_reg;
    assign cmd_xfer  = cmd.valid && !skid_valid_reg;

    // result register is empty or is drained this cycle
    assign out_free  = !out_valid_reg || res.ready;

    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

    // state advances at each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            for (int i = 0; i < MAX_PLANES; i++)
            begin
                plane_values_reg[i] <= '0;
            end
        end
        else if (cmd_xfer)
        begin
            state_reg        <= state_next;
            plane_values_reg <= plane_values_next;
        end
    end

    // output side: skid contents go out first, so order is kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || cmd_xfer;
            skid_valid_reg <= 1'b0;
        end
        else if (cmd_xfer)
        begin
            // result register stalled, park the new result
            skid_valid_reg <= 1'b1;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        else if (cmd_xfer)
        begin
            skid_reg <= result;
        end
    end

endmodule

// File: hdl/icpd_decode.sv
// ----------------------------------------------------------------------------
// icpd_decode
// combinational decode of one item against the current dispatcher state
// ----------------------------------------------------------------------------
module icpd_decode import icpd_pkg::*;
#(
    parameter int MAX_PLANES = MAX_PLANES_DEFAULT
)
(
    input  cmd_t        cmd,
    input  ctrl_state_t state,
    input  logic [7:0]  plane_values [MAX_PLANES],
    output ctrl_state_t state_next,
    output logic [7:0]  plane_values_next [MAX_PLANES],
    output res_t        result
);

    localparam logic [7:0] MAX_PLANES_B = 8'(MAX_PLANES);

    logic [7:0] load_bytes [PLANE_SLOTS];
    logic [7:0] len_less;
    logic [7:0] load_count;
    logic [7:0] short_count;
    logic [2:0] step_index;
    logic [1:0] tick_index;
    logic [7:0] tick_value;

    assign load_bytes[0] = cmd.byte3;
    assign load_bytes[1] = cmd.byte4;
    assign load_bytes[2] = cmd.byte5;

    assign len_less    = cmd.byte1 - LEN_OVERHEAD;
    assign load_count  = (len_less > MAX_PLANES_B) ? MAX_PLANES_B : len_less;
    assign short_count = (len_less > SHORT_DATA_MAX) ? SHORT_DATA_MAX : len_less;

    // wrap round the loaded plane count
    assign step_index = {1'b0, state.plane_index} + 3'd1;
    assign tick_index = (step_index >= {1'b0, state.plane_count}) ? 2'd0 : step_index[1:0];

    always_comb
    begin
        tick_value = '0;
        for (int i = 0; i < MAX_PLANES; i++)
        begin
            if (tick_index == 2'(i))
            begin
                tick_value = plane_values[i];
            end
        end
    end

    always_comb
    begin
        result            = '0;
        state_next        = state;
        plane_values_next = plane_values;

        if (cmd.opcode == OP_TICK)
        begin
            if (state.plane_count != 2'd0)
            begin
                state_next.plane_index = tick_index;
                result.write_valid     = 1'b1;
                result.dev_address     = LENS_ADDR;
                result.reg_byte        = LENS_REG;
                result.data_count      = LENS_DATA_COUNT;
                result.data_0          = tick_value;
                result.data_1          = LENS_TAIL;
            end
        end
        else if (cmd.byte0 == LOCAL_MARK)
        begin
            if (cmd.byte1 == LEN_OVERHEAD)
            begin
                if (cmd.byte2 == LOCAL_CMD_IMU)
                begin
                    state_next.imu_en = 1'b1;
                end
            end
            else if (cmd.byte1 > LEN_OVERHEAD && cmd.byte2 == LOCAL_CMD_PLANES)
            begin
                state_next.plane_index = 2'd0;
                state_next.plane_count = load_count[1:0];
                for (int i = 0; i < MAX_PLANES; i++)
                begin
                    if (8'(i) < load_count)
                    begin
                        plane_values_next[i] = load_bytes[i];
                    end
                end
            end
        end
        else if (cmd.byte0[0])
        begin
            // full form: register byte and four data bytes
            result.write_valid = 1'b1;
            result.dev_address = {cmd.byte0[7:1], 1'b0};
            result.reg_byte    = cmd.byte1;
            result.data_count  = FULL_DATA_COUNT;
            result.data_0      = cmd.byte2;
            result.data_1      = cmd.byte3;
            result.data_2      = cmd.byte4;
            result.data_3      = cmd.byte5;
        end
        else if (cmd.byte1 >= LEN_OVERHEAD)
        begin
            // short form: length byte sets the data count
            result.write_valid = 1'b1;
            result.dev_address = cmd.byte0;
            result.reg_byte    = cmd.byte2;
            result.data_count  = short_count[2:0];
            result.data_0      = (short_count >= 8'd1) ? cmd.byte3 : 8'd0;
            result.data_1      = (short_count >= 8'd2) ? cmd.byte4 : 8'd0;
            result.data_2      = (short_count >= 8'd3) ? cmd.byte5 : 8'd0;
        end

        result.imu_enabled = state_next.imu_en;
        result.plane_now   = state_next.plane_index;
    end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the i2c command packet dispatcher core
// ----------------------------------------------------------------------------
// Command packets and frame ticks are queued by the stimulus process and
// driven onto cmd by a clocked driver. Each accepted item is run through a
// local model of the dispatcher, which keeps its own copy of the imu flag and
// of the lens plane table. The modelled result is queued. A clocked monitor
// then compares every result transfer, field by field, with the oldest queued
// one. Sender and receiver idle at varied rates. Two pressure steps are
// added: a long result stall that fills the block, and a drain pause.
// ----------------------------------------------------------------------------
module tb_top;
    import icpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PLANE_LIMIT   = MAX_PLANES_DEFAULT;
    localparam int HOLD_CYCLES   = 80;       // long receiver stall
    localparam int PHASE_ITEMS   = 600;      // random items per idling phase, besides the burst
    localparam int BURST_ITEMS   = 40;       // items offered during the stall
    localparam int TAIL_CYCLES   = 8;        // settle time after the last result

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    icpd_cmd_if cmd_ch ();
    icpd_res_if res_ch ();

    i2c_command_packet_dispatcher_core #(.MAX_PLANES(PLANE_LIMIT)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // items waiting to be driven, and results still owed by the block
    cmd_t pending_cmds [$];
    res_t owed_results [$];

    // idle rates in percent, set by the stimulus process
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    // receiver hold-off, raised on request and dropped again by the hold-off process
    logic sink_hold = 1'b0;
    event sink_hold_go;

    int errors      = 0;
    int items_sent  = 0;
    int ticks_sent  = 0;
    int locals_sent = 0;
    int results_ok  = 0;

    // dispatcher state as the model sees it
    logic       imu_flag;
    logic [1:0] plane_cnt;
    logic [1:0] plane_idx;
    logic [7:0] plane_val [PLANE_SLOTS];

    // ------------------------------------------------------------------
    // model of one item: updates the local state, returns the result
    // ------------------------------------------------------------------
    function automatic res_t dispatch_predict(input cmd_t c);
        res_t       r;
        logic [7:0] b [6];
        logic [7:0] d [4];
        int         n;
        r = '0;
        d = '{default: 8'h00};
        b = '{c.byte0, c.byte1, c.byte2, c.byte3, c.byte4, c.byte5};
        if (c.opcode == OP_TICK)
        begin
            // frame tick: step round the loaded planes, nothing when empty
            if (plane_cnt != 2'd0)
            begin
                plane_idx = 2'((int'(plane_idx) + 1) % int'(plane_cnt));
                r.write_valid = 1'b1;
                r.dev_address = LENS_ADDR;
                r.reg_byte    = LENS_REG;
                r.data_count  = LENS_DATA_COUNT;
                d[0]          = plane_val[plane_idx];
                d[1]          = LENS_TAIL;
            end
        end
        else if (b[0] == LOCAL_MARK)
        begin
            if (b[1] == LEN_OVERHEAD)
            begin
                if (b[2] == LOCAL_CMD_IMU)
                    imu_flag = 1'b1;
            end
            else if (b[1] > LEN_OVERHEAD && b[2] == LOCAL_CMD_PLANES)
            begin
                // plane load: count saturates at the plane limit
                n = int'(b[1]) - int'(LEN_OVERHEAD);
                if (n > PLANE_LIMIT)
                    n = PLANE_LIMIT;
                plane_idx = 2'd0;
                plane_cnt = 2'(n);
                for (int i = 0; i < n; i++)
                    plane_val[i] = b[3 + i];
            end
        end
        else if (b[0][0])
        begin
            // full form: four data bytes, write bit cleared
            r.write_valid = 1'b1;
            r.dev_address = b[0] & 8'hFE;
            r.reg_byte    = b[1];
            r.data_count  = FULL_DATA_COUNT;
            for (int i = 0; i < 4; i++)
                d[i] = b[2 + i];
        end
        else if (b[1] >= LEN_OVERHEAD)
        begin
            // short form: length byte less overhead, clamped
            n = int'(b[1]) - int'(LEN_OVERHEAD);
            if (n > int'(SHORT_DATA_MAX))
                n = int'(SHORT_DATA_MAX);
            r.write_valid = 1'b1;
            r.dev_address = b[0];
            r.reg_byte    = b[2];
            r.data_count  = 3'(n);
            for (int i = 0; i < n; i++)
                d[i] = b[3 + i];
        end
        r.data_0      = d[0];
        r.data_1      = d[1];
        r.data_2      = d[2];
        r.data_3      = d[3];
        r.imu_enabled = imu_flag;
        r.plane_now   = plane_idx;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------
    function automatic cmd_t packet(input logic [7:0] b0, b1, b2, b3, b4, b5);
        cmd_t c;
        c.opcode = OP_PACKET;
        c.byte0  = b0;
        c.byte1  = b1;
        c.byte2  = b2;
        c.byte3  = b3;
        c.byte4  = b4;
        c.byte5  = b5;
        return c;
    endfunction

    // frame tick, packet bytes filled with noise since the block ignores them
    function automatic cmd_t frame_tick();
        cmd_t c;
        c = packet(8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom));
        c.opcode = OP_TICK;
        return c;
    endfunction

    // mostly well-formed traffic: ticks, local commands, full and short writes
    function automatic cmd_t random_item();
        cmd_t c;
        int   pick;
        c = packet(8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom));
        pick = $urandom_range(99);
        if (pick < 25)
            c = frame_tick();
        else if (pick < 37)
        begin
            // local command, usually a sensible imu enable or plane load
            c.byte0 = LOCAL_MARK;
            c.byte1 = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(2, 6));
            c.byte2 = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
        end
        else if (pick < 65)
            c.byte0[0] = 1'b1;
        else
        begin
            c.byte0[0] = 1'b0;
            if (pick < 90)
                c.byte1 = 8'($urandom_range(0, 6));
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // driver: offers the next queued item, holds it until the transfer
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.data  <= '0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                // transfer taken: model it now so expectations stay in order
                owed_results.push_back(dispatch_predict(cmd_ch.data));
                items_sent++;
                if (cmd_ch.data.opcode == OP_TICK)
                    ticks_sent++;
                else if (cmd_ch.data.byte0 == LOCAL_MARK)
                    locals_sent++;
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    cmd_ch.data  <= pending_cmds.pop_front();
                    cmd_ch.valid <= 1'b1;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // receiver ready, with random idling and the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
    end

    // long hold-off, counted on falling edges so the ready driver sees it cleanly
    always
    begin
        @(sink_hold_go);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        sink_hold = 1'b0;
    end

    // ------------------------------------------------------------------
    // monitor: every result transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready)
        begin
            res_t want;
            res_t got;
            got = res_ch.data;
            if (owed_results.size() == 0)
                report_mismatch("result transfer with nothing expected");
            else
            begin
                want = owed_results.pop_front();
                compare_field("write_valid", 8'(got.write_valid), 8'(want.write_valid));
                compare_field("dev_address", got.dev_address, want.dev_address);
                compare_field("reg_byte",    got.reg_byte,    want.reg_byte);
                compare_field("data_count",  8'(got.data_count), 8'(want.data_count));
                compare_field("data_0",      got.data_0,      want.data_0);
                compare_field("data_1",      got.data_1,      want.data_1);
                compare_field("data_2",      got.data_2,      want.data_2);
                compare_field("data_3",      got.data_3,      want.data_3);
                compare_field("imu_enabled", 8'(got.imu_enabled), 8'(want.imu_enabled));
                compare_field("plane_now",   8'(got.plane_now),   8'(want.plane_now));
                results_ok++;
            end
        end
    end

    // sender pause: nothing queued, nothing on the channel, nothing owed
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || cmd_ch.valid || owed_results.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int k;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        res_ch.ready = 1'b0;

        // model state after reset
        imu_flag  = 1'b0;
        plane_cnt = 2'd0;
        plane_idx = 2'd0;
        plane_val = '{default: 8'h00};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        src_idle_pct  = 8;
        sink_idle_pct = 49;

        // directed part
        pending_cmds.push_back(frame_tick());                                    // no planes yet
        pending_cmds.push_back(packet(LOCAL_MARK, 8'd2, 8'h07, 8'h00, 8'h00, 8'h00));  // imu, wrong sub
        pending_cmds.push_back(packet(LOCAL_MARK, 8'd1, 8'h00, 8'hFF, 8'hFF, 8'hFF));  // too short
        pending_cmds.push_back(packet(LOCAL_MARK, 8'hFF, 8'h05, 8'h11, 8'h22, 8'h33)); // unknown
        pending_cmds.push_back(packet(LOCAL_MARK, 8'd2, 8'h00, 8'h00, 8'h00, 8'h00));  // imu on
        pending_cmds.push_back(packet(LOCAL_MARK, 8'd3, 8'h01, 8'hA5, 8'h00, 8'h00));  // one plane
        pending_cmds.push_back(frame_tick());
        pending_cmds.push_back(frame_tick());
        pending_cmds.push_back(packet(LOCAL_MARK, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'h5A)); // clamp at 3
        repeat (4) pending_cmds.push_back(frame_tick());
        pending_cmds.push_back(packet(LOCAL_MARK, 8'd4, 8'h01, 8'h3C, 8'hC3, 8'h99));  // two planes
        repeat (3) pending_cmds.push_back(frame_tick());
        pending_cmds.push_back(packet(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));  // full form
        pending_cmds.push_back(packet(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        pending_cmds.push_back(packet(8'h00, 8'd0, 8'h12, 8'h34, 8'h56, 8'h78));   // short, no write
        pending_cmds.push_back(packet(8'h40, 8'd1, 8'h12, 8'h34, 8'h56, 8'h78));
        pending_cmds.push_back(packet(8'h40, 8'd2, 8'hFF, 8'h34, 8'h56, 8'h78));   // no data
        pending_cmds.push_back(packet(8'h40, 8'd3, 8'h81, 8'hFF, 8'h56, 8'h78));
        pending_cmds.push_back(packet(8'hFC, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF));  // clamp at 3
        wait_drained();

        // random part over three idling mixes
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct  = 8;
                    sink_idle_pct = 49;
                end
                1:
                begin
                    src_idle_pct  = 49;
                    sink_idle_pct = 8;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                while (pending_cmds.size() >= 8)
                    @(negedge clk);
                pending_cmds.push_back(random_item());
                if (k == PHASE_ITEMS / 2)
                begin
                    // stall the results while items keep coming, so cmd backs up
                    -> sink_hold_go;
                    repeat (BURST_ITEMS) pending_cmds.push_back(random_item());
                end
                if (k == (3 * PHASE_ITEMS) / 4)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        if (owed_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", owed_results.size()));

        $display("run: %0d items (%0d frame ticks, %0d local commands), %0d results checked",
                 items_sent, ticks_sent, locals_sent, results_ok);
        $display("run: three idling mixes, long result stalls and drain pauses, %0d mismatches",
                 errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
hdl/icpd_pkg.sv
hdl/icpd_cmd_if.sv
hdl/icpd_res_if.sv
hdl/icpd_decode.sv
hdl/i2c_command_packet_dispatcher_core.sv
tb/tb_top.sv
